/* hw/rtl/lftt_pkg.sv */
// ----------------------------------------------------------------------------
// lftt_pkg
// shared types and codes for the lru fetch tracking tag table
// ----------------------------------------------------------------------------
package lftt_pkg;

  localparam int unsigned SLOTS_DEF      = 64;
  localparam int unsigned FREE_DEPTH_DEF = 16;

  localparam logic [15:0] FETCH_TIMEOUT_RST = 16'd600;
  localparam logic [15:0] FAIL_RETRY_RST    = 16'd1800;
  localparam logic [15:0] QUEUE_RETRY_RST   = 16'd60;

  // register indexes
  localparam logic [1:0] REG_FETCH_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_FAIL_RETRY    = 2'd1;
  localparam logic [1:0] REG_QUEUE_RETRY   = 2'd2;

  // operation codes
  localparam logic [2:0] F_TICK    = 3'd0;
  localparam logic [2:0] F_REQUEST = 3'd1;
  localparam logic [2:0] F_PROBE   = 3'd2;
  localparam logic [2:0] F_FAIL    = 3'd3;
  localparam logic [2:0] F_FILL    = 3'd4;
  localparam logic [2:0] F_DRAIN   = 3'd5;
  localparam logic [2:0] F_CLAIM   = 3'd6;

  // slot states
  localparam logic [1:0] ST_EMPTY    = 2'd0;
  localparam logic [1:0] ST_FETCHING = 2'd1;
  localparam logic [1:0] ST_READY    = 2'd2;
  localparam logic [1:0] ST_FAILED   = 2'd3;

  // result codes
  localparam logic [3:0] R_HIT      = 4'd0;
  localparam logic [3:0] R_INFLIGHT = 4'd1;
  localparam logic [3:0] R_NEGATIVE = 4'd2;
  localparam logic [3:0] R_MISS     = 4'd3;
  localparam logic [3:0] R_NOSLOT   = 4'd4;
  localparam logic [3:0] R_COLD     = 4'd5;
  localparam logic [3:0] R_DONE     = 4'd6;
  localparam logic [3:0] R_RELEASE  = 4'd7;
  localparam logic [3:0] R_DEFERRED = 4'd8;

  // command class decided by the front end
  typedef enum logic [2:0] {
    CL_SIMPLE = 3'b001,
    CL_SCAN   = 3'b010,
    CL_DRAIN  = 3'b100
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [2:0]  func;
    logic [63:0] item_key;
    logic [1:0]  variant;
    logic        retry_select;
    logic [31:0] fill_handle;
  } cmd_t;

  typedef struct packed {
    logic [63:0] key;
    logic [1:0]  variant;
    logic [1:0]  state;
    logic [31:0] handle;
    logic [31:0] deadline;
    logic [31:0] used_at;
  } entry_t;

endpackage

/* hw/rtl/lftt_front.sv */
// ----------------------------------------------------------------------------
// lftt_front
// accepts commands, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module lftt_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           func,
  input  logic [63:0]          item_key,
  input  logic [1:0]           variant,
  input  logic                 retry_select,
  input  logic [31:0]          fill_handle,
  output logic                 q_valid,
  output lftt_pkg::cmd_t       q_cmd,
  input  logic                 q_pop
);

  lftt_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  lftt_pkg::cls_t cls;

  always_comb begin
    case (func)
      lftt_pkg::F_REQUEST, lftt_pkg::F_PROBE, lftt_pkg::F_FAIL,
      lftt_pkg::F_FILL, lftt_pkg::F_CLAIM: cls = lftt_pkg::CL_SCAN;
      lftt_pkg::F_DRAIN: cls = lftt_pkg::CL_DRAIN;
      default: cls = lftt_pkg::CL_SIMPLE;
    endcase
  end

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{cls: cls, func: func, item_key: item_key, variant: variant,
                     retry_select: retry_select, fill_handle: fill_handle};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* hw/rtl/lftt_back.sv */
// ----------------------------------------------------------------------------
// lftt_back
// executes commands: slot scan, replacement, update and deferred-free drain
// ----------------------------------------------------------------------------
module lftt_back #(
  parameter int unsigned SLOTS      = lftt_pkg::SLOTS_DEF,
  parameter int unsigned FREE_DEPTH = lftt_pkg::FREE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lftt_pkg::cmd_t q_cmd,
  output logic           q_pop,
  input  logic [15:0]    fetch_timeout,
  input  logic [15:0]    fail_retry,
  input  logic [15:0]    queue_retry,
  output logic           result_valid,
  output logic [3:0]     status,
  output logic [31:0]    out_handle,
  output logic           last
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned DW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(FREE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_DRD  = 5'b01000,
    S_DOUT = 5'b10000
  } state_t;

  state_t          state;
  lftt_pkg::cmd_t  cmd;
  logic [31:0]     tick_count;

  lftt_pkg::entry_t mem [SLOTS];
  lftt_pkg::entry_t rd_q;
  logic [SLOTS-1:0] slot_valid;
  logic [AW:0]      scan_addr;
  logic             p_v;
  logic [AW-1:0]    p_idx;

  logic             m_found;
  logic [AW-1:0]    m_idx;
  lftt_pkg::entry_t m_ent;
  logic             f_found;
  logic [AW-1:0]    f_idx;
  logic             nf_found;
  logic [AW-1:0]    nf_idx;
  logic [31:0]      nf_last;
  logic [31:0]      nf_h;
  logic             any_found;
  logic [AW-1:0]    any_idx;
  logic [31:0]      any_last;
  logic [31:0]      any_h;

  logic [31:0]      dmem [FREE_DEPTH];
  logic [CW-1:0]    dcount;
  logic [CW-1:0]    d_idx;
  logic [31:0]      d_rd;

  // execute step results
  logic             ex_write;
  logic [AW-1:0]    ex_idx;
  lftt_pkg::entry_t ex_ent;
  logic             ex_push;
  logic [31:0]      ex_push_h;
  logic [3:0]       ex_status;
  logic [31:0]      ex_handle;
  logic             ev_ok;
  logic [AW-1:0]    ev_idx;
  logic [31:0]      ev_h;
  logic [3:0]       m_cls;
  logic             rd_match;

  function automatic logic [3:0] classify(lftt_pkg::entry_t e, logic [31:0] t);
    logic [3:0] r;
    r = lftt_pkg::R_COLD;
    if (e.state == lftt_pkg::ST_READY && e.handle != 32'd0) r = lftt_pkg::R_HIT;
    else if (e.state == lftt_pkg::ST_FETCHING && t < e.deadline) r = lftt_pkg::R_INFLIGHT;
    else if (e.state == lftt_pkg::ST_FAILED && t < e.deadline) r = lftt_pkg::R_NEGATIVE;
    return r;
  endfunction

  assign q_pop = (state == S_IDLE) && q_valid;

  // single read port, registered data
  always_ff @(posedge clk) begin
    rd_q <= mem[scan_addr[AW-1:0]];
    if (ex_write) mem[ex_idx] <= ex_ent;
  end

  always_ff @(posedge clk) begin
    d_rd <= dmem[d_idx[DW-1:0]];
    if (ex_push) dmem[dcount[DW-1:0]] <= ex_push_h;
  end

  assign rd_match = slot_valid[p_idx] && rd_q.variant == cmd.variant &&
                    rd_q.key == cmd.item_key;
  assign m_cls    = classify(m_ent, tick_count);

  always_comb begin
    if (f_found) begin
      ev_idx = f_idx;
      ev_h   = 32'd0;
    end else if (nf_found) begin
      ev_idx = nf_idx;
      ev_h   = nf_h;
    end else begin
      ev_idx = any_idx;
      ev_h   = any_h;
    end
    ex_push_h = ev_h;
    ev_ok     = !(ev_h != 32'd0 && dcount >= CW'(FREE_DEPTH));

    ex_write  = 1'b0;
    ex_push   = 1'b0;
    ex_idx    = m_idx;
    ex_ent    = m_ent;
    ex_status = lftt_pkg::R_DONE;
    ex_handle = 32'd0;

    if (state == S_EXEC) begin
      case (cmd.func)
        lftt_pkg::F_PROBE: begin
          ex_status = m_found ? m_cls : lftt_pkg::R_COLD;
          ex_handle = (m_found && m_cls == lftt_pkg::R_HIT) ? m_ent.handle : 32'd0;
        end
        lftt_pkg::F_FAIL: begin
          ex_write       = m_found;
          ex_ent.state   = lftt_pkg::ST_FAILED;
          ex_ent.deadline = tick_count +
                            32'(cmd.retry_select ? queue_retry : fail_retry);
        end
        lftt_pkg::F_FILL: begin
          if (m_found) begin
            ex_write = 1'b1;
            if (m_ent.handle != 32'd0 && m_ent.handle != cmd.fill_handle) begin
              ex_status = lftt_pkg::R_RELEASE;
              ex_handle = m_ent.handle;
            end
          end else if (ev_ok) begin
            ex_write       = 1'b1;
            ex_push        = ev_h != 32'd0;
            ex_idx         = ev_idx;
            ex_ent.key     = cmd.item_key;
            ex_ent.variant = cmd.variant;
          end else begin
            ex_status = lftt_pkg::R_RELEASE;
            ex_handle = cmd.fill_handle;
          end
          ex_ent.handle   = cmd.fill_handle;
          ex_ent.state    = lftt_pkg::ST_READY;
          ex_ent.deadline = 32'd0;
          ex_ent.used_at  = tick_count;
        end
        lftt_pkg::F_REQUEST, lftt_pkg::F_CLAIM: begin
          ex_ent.used_at  = tick_count;
          ex_ent.deadline = tick_count + 32'(fetch_timeout);
          ex_ent.state    = lftt_pkg::ST_FETCHING;
          if (m_found && cmd.func == lftt_pkg::F_REQUEST &&
              m_cls != lftt_pkg::R_COLD) begin
            ex_write        = 1'b1;
            ex_ent          = m_ent;
            ex_ent.used_at  = tick_count;
            ex_status       = m_cls;
            ex_handle       = (m_cls == lftt_pkg::R_HIT) ? m_ent.handle : 32'd0;
          end else if (m_found) begin
            ex_write  = 1'b1;
            ex_status = lftt_pkg::R_MISS;
          end else if (ev_ok) begin
            ex_write       = 1'b1;
            ex_push        = ev_h != 32'd0;
            ex_idx         = ev_idx;
            ex_ent.key     = cmd.item_key;
            ex_ent.variant = cmd.variant;
            ex_ent.handle  = 32'd0;
            ex_status      = lftt_pkg::R_MISS;
          end else begin
            ex_status = lftt_pkg::R_NOSLOT;
          end
        end
        default: ex_status = lftt_pkg::R_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd <= q_cmd;
    if (state == S_IDLE) begin
      m_found   <= 1'b0;
      f_found   <= 1'b0;
      nf_found  <= 1'b0;
      any_found <= 1'b0;
    end else if (state == S_SCAN && p_v) begin
      if (rd_match && !m_found) begin
        m_found <= 1'b1;
        m_idx   <= p_idx;
        m_ent   <= rd_q;
      end
      if (!slot_valid[p_idx] && !f_found) begin
        f_found <= 1'b1;
        f_idx   <= p_idx;
      end
      if (slot_valid[p_idx] && rd_q.state != lftt_pkg::ST_FETCHING &&
          (!nf_found || rd_q.used_at < nf_last)) begin
        nf_found <= 1'b1;
        nf_idx   <= p_idx;
        nf_last  <= rd_q.used_at;
        nf_h     <= rd_q.handle;
      end
      if (slot_valid[p_idx] && (!any_found || rd_q.used_at < any_last)) begin
        any_found <= 1'b1;
        any_idx   <= p_idx;
        any_last  <= rd_q.used_at;
        any_h     <= rd_q.handle;
      end
    end
    p_idx <= scan_addr[AW-1:0];
    if (state == S_DOUT) begin
      status     <= lftt_pkg::R_DEFERRED;
      out_handle <= d_rd;
      last       <= (d_idx + CW'(1) == dcount);
    end else begin
      status     <= ex_status;
      out_handle <= ex_handle;
      last       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_count   <= 32'd0;
      slot_valid   <= '0;
      dcount       <= '0;
      d_idx        <= '0;
      scan_addr    <= '0;
      p_v          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ex_write) slot_valid[ex_idx] <= 1'b1;
      if (ex_push) dcount <= dcount + CW'(1);
      case (state)
        S_IDLE: begin
          scan_addr    <= '0;
          d_idx        <= '0;
          p_v          <= 1'b0;
          result_valid <= q_valid && q_cmd.cls != lftt_pkg::CL_SCAN &&
                          !(q_cmd.cls == lftt_pkg::CL_DRAIN && dcount != '0);
          if (q_valid) begin
            case (q_cmd.cls)
              lftt_pkg::CL_SCAN: state <= S_SCAN;
              lftt_pkg::CL_DRAIN: begin
                if (dcount != '0) state <= S_DRD;
              end
              default: begin
                if (q_cmd.func == lftt_pkg::F_TICK) tick_count <= tick_count + 32'd1;
              end
            endcase
          end
        end
        S_SCAN: begin
          result_valid <= 1'b0;
          p_v          <= (scan_addr != (AW+1)'(SLOTS));
          if (scan_addr != (AW+1)'(SLOTS)) scan_addr <= scan_addr + (AW+1)'(1);
          if (p_v && p_idx == AW'(SLOTS - 1)) state <= S_EXEC;
        end
        S_EXEC: begin
          result_valid <= 1'b1;
          p_v          <= 1'b0;
          state        <= S_IDLE;
        end
        S_DRD: begin
          result_valid <= 1'b0;
          p_v          <= 1'b0;
          state        <= S_DOUT;
        end
        S_DOUT: begin
          result_valid <= 1'b1;
          p_v          <= 1'b0;
          if (d_idx + CW'(1) == dcount) begin
            dcount <= '0;
            state  <= S_IDLE;
          end else begin
            d_idx <= d_idx + CW'(1);
            state <= S_DRD;
          end
        end
        default: begin
          result_valid <= 1'b0;
          p_v          <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/lru_fetch_tracking_tag_table.sv */
// ----------------------------------------------------------------------------
// lru_fetch_tracking_tag_table
// fully associative tag table with lru replacement, negative caching and a
// deferred-free list for evicted handles
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  command   start, busy, func, item_key, variant,            in (busy out)
//            retry_select, fill_handle
//  result    result_valid, status, out_handle, last           out
//  config    cfg_we, cfg_index, cfg_data                      in
//
//  a command beat is taken when start is high and busy is low; busy rises
//  while two beats wait in the queue behind a command still executing;
//  tick, empty drain and unused codes finish in the idle back end without a
//  scan; lookup commands scan every slot through the slot memory's single
//  read port before their result beat; drain reads one deferred handle, then
//  gives it as a result beat, and repeats until the list is empty
//  sync reset clears valid bits, counters and control; no clearing pass
//  result beats appear for one cycle each, the receiver cannot stall them
// ----------------------------------------------------------------------------
module lru_fetch_tracking_tag_table #(
  parameter int unsigned SLOTS      = lftt_pkg::SLOTS_DEF,
  parameter int unsigned FREE_DEPTH = lftt_pkg::FREE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func,
  input  logic [63:0] item_key,
  input  logic [1:0]  variant,
  input  logic        retry_select,
  input  logic [31:0] fill_handle,
  output logic        result_valid,
  output logic [3:0]  status,
  output logic [31:0] out_handle,
  output logic        last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // timeout registers
  logic [15:0] fetch_timeout;
  logic [15:0] fail_retry;
  logic [15:0] queue_retry;

  // queue between front and back
  logic           q_valid;
  lftt_pkg::cmd_t q_cmd;
  logic           q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_timeout <= lftt_pkg::FETCH_TIMEOUT_RST;
      fail_retry    <= lftt_pkg::FAIL_RETRY_RST;
      queue_retry   <= lftt_pkg::QUEUE_RETRY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lftt_pkg::REG_FETCH_TIMEOUT: fetch_timeout <= cfg_data;
        lftt_pkg::REG_FAIL_RETRY:    fail_retry    <= cfg_data;
        lftt_pkg::REG_QUEUE_RETRY:   queue_retry   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify
  lftt_front u_front (
    .clk, .rst, .start, .busy, .func, .item_key, .variant, .retry_select,
    .fill_handle, .q_valid, .q_cmd, .q_pop
  );

  // back: scan, replace, update, drain
  lftt_back #(.SLOTS(SLOTS), .FREE_DEPTH(FREE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .fetch_timeout, .fail_retry,
    .queue_retry, .result_valid, .status, .out_handle, .last
  );

`ifndef SYNTH
  // only deferred-free beats may leave last low
  a_last_single : assert property (@(posedge clk) disable iff (rst)
    result_valid && status != lftt_pkg::R_DEFERRED |-> last)
    else $error("non-drain result without last");

  // no result beat right after reset
  a_reset_quiet : assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result beat after reset");

  // a result carrying no handle code must show zero handle
  a_handle_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == lftt_pkg::R_DONE || status == lftt_pkg::R_MISS ||
    status == lftt_pkg::R_COLD || status == lftt_pkg::R_NOSLOT) |-> out_handle == 32'd0)
    else $error("handle on handleless result");
`endif

endmodule
